/* rtl/lmtc_pkg.sv */
// Shared types and constants of the LCD mode timing controller.
`default_nettype none
package lmtc_pkg;

   // Request kinds.
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;
   localparam logic [1:0] ACT_NONE  = 2'd3;

   // Register selects.
   localparam logic [1:0] REG_CONTROL = 2'd0;
   localparam logic [1:0] REG_STATUS  = 2'd1;
   localparam logic [1:0] REG_LINE    = 2'd2;
   localparam logic [1:0] REG_COMPARE = 2'd3;

   // Mode codes held in status bits 1:0.
   localparam logic [1:0] MODE_HBLANK = 2'd0;
   localparam logic [1:0] MODE_VBLANK = 2'd1;
   localparam logic [1:0] MODE_OAM    = 2'd2;
   localparam logic [1:0] MODE_XFER   = 2'd3;

   // Phase and line lengths in dots, and the dot counter's saturation limit.
   localparam logic [10:0] DOTS_OAM    = 11'd80;
   localparam logic [10:0] DOTS_XFER   = 11'd172;
   localparam logic [10:0] DOTS_HBLANK = 11'd204;
   localparam logic [10:0] DOTS_LINE   = 11'd456;
   localparam logic [10:0] DOT_MAX     = 11'd1023;

   // Line numbers.
   localparam logic [7:0] FIRST_VBLANK = 8'd144;
   localparam logic [7:0] LAST_LINE    = 8'd153;

   // Register reset values and masks.
   localparam logic [7:0] CONTROL_RESET = 8'h91;
   localparam logic [7:0] STATUS_RESET  = 8'h85;
   localparam logic [7:0] STATUS_KEEP   = 8'h07;
   localparam logic [7:0] STATUS_WRITE  = 8'hF8;
   localparam logic [7:0] STATUS_READ   = 8'h80;

   // Status and control bit positions.
   localparam int unsigned ST_COINC     = 2;
   localparam int unsigned ST_EN_HBLANK = 3;
   localparam int unsigned ST_EN_VBLANK = 4;
   localparam int unsigned ST_EN_OAM    = 5;
   localparam int unsigned ST_EN_COINC  = 6;
   localparam int unsigned CTRL_LCD_ON  = 7;

   // Architectural state of the controller.
   typedef struct packed {
      logic [7:0] control;
      logic [7:0] status;
      logic [7:0] line;
      logic [7:0] compare;
      logic [9:0] dot;
   } lcd_state_type;

   // One request.
   typedef struct packed {
      logic [1:0] action;
      logic [7:0] cycles;
      logic [1:0] reg_sel;
      logic [7:0] write_data;
   } lcd_item_type;

   // One result.
   typedef struct packed {
      logic [7:0] read_data;
      logic       vblank_irq;
      logic       status_irq;
      logic       frame_done;
      logic       line_start;
      logic [7:0] line_num;
      logic [1:0] cur_mode;
   } lcd_result_type;

endpackage
`default_nettype wire

/* rtl/lcd_mode_timing_controller.sv */
// Top level of the LCD mode timing controller: request register, state and response register.
// Usage:
//   Requests arrive on the req_ channel (valid/ready). Each is a tick carrying a
//   dot count, or a read or write of the control, status, current line or line
//   compare register. Every request yields exactly one response on the rsp_
//   channel, carrying read data, the VBlank and status interrupt pulses, the
//   frame-done pulse, the line-render strobe, and the line and mode after it.
//   A request accepted at one clock edge is registered in the request register,
//   processed by a single pass of next-state logic as it advances into the
//   response register, and its response is valid from then on. One request
//   is accepted per cycle while the receiver keeps rsp_ready high; the limit is
//   the single state update per cycle in the step logic.
//   Synchronous reset empties both registers and loads control 0x91, status
//   0x85 (VBlank), line 0, compare 0 and a zero dot counter.
//   When the receiver holds rsp_ready low, the held response stays put, the
//   request register fills, and req_ready then drops until the response is taken.
`default_nettype none
module lcd_mode_timing_controller (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_action,
   input  wire logic [7:0] req_cycles,
   input  wire logic [1:0] req_reg_sel,
   input  wire logic [7:0] req_write_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_read_data,
   output logic            rsp_vblank_irq,
   output logic            rsp_status_irq,
   output logic            rsp_frame_done,
   output logic            rsp_line_start,
   output logic [7:0]      rsp_line_num,
   output logic [1:0]      rsp_cur_mode
);
   import lmtc_pkg::*;

   logic           in_valid_ff;
   lcd_item_type   in_item_ff;
   lcd_state_type  state_ff;
   lcd_state_type  state_in;
   logic           rsp_valid_ff;
   lcd_result_type rsp_ff;
   lcd_result_type rsp_in;
   logic           advance;

   // A request moves on when the response register is empty or being emptied.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   lmtc_step u_step (
      .cur_state (state_ff),
      .item      (in_item_ff),
      .nxt_state (state_in),
      .result    (rsp_in)
   );

   // Request register, controller state and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         state_ff.control <= CONTROL_RESET;
         state_ff.status  <= STATUS_RESET;
         state_ff.line    <= '0;
         state_ff.compare <= '0;
         state_ff.dot     <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff.action     <= req_action;
         in_item_ff.cycles     <= req_cycles;
         in_item_ff.reg_sel    <= req_reg_sel;
         in_item_ff.write_data <= req_write_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_ff.read_data;
   assign rsp_vblank_irq = rsp_ff.vblank_irq;
   assign rsp_status_irq = rsp_ff.status_irq;
   assign rsp_frame_done = rsp_ff.frame_done;
   assign rsp_line_start = rsp_ff.line_start;
   assign rsp_line_num   = rsp_ff.line_num;
   assign rsp_cur_mode   = rsp_ff.cur_mode;

   // The line counter never leaves the frame.
   a_line_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.line_num <= LAST_LINE))
      else $error("line number beyond the last line");

   // A VBlank interrupt comes only with entry to VBlank.
   a_vblank_mode : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.vblank_irq) |-> (rsp_ff.cur_mode == MODE_VBLANK))
      else $error("VBlank interrupt outside VBlank");

   // Frame completion is reported on the first VBlank line.
   a_frame_line : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.frame_done) |->
         (rsp_ff.line_num == FIRST_VBLANK && rsp_ff.vblank_irq))
      else $error("frame done away from the first VBlank line");

   // The render strobe comes with entry to transfer on a visible line.
   a_line_start : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.line_start) |->
         (rsp_ff.cur_mode == MODE_XFER && rsp_ff.line_num < FIRST_VBLANK))
      else $error("line start outside transfer on a visible line");

   // State moves only when a request is processed.
   a_state_hold : assert property (@(posedge clock) disable iff (reset)
      $past(!reset && !advance) |-> $stable(state_ff))
      else $error("state changed without a request");

endmodule
`default_nettype wire

/* rtl/lmtc_step.sv */
// Next-state and result logic for one request of the LCD mode timing controller.
`default_nettype none
module lmtc_step (
   input  lmtc_pkg::lcd_state_type  cur_state,
   input  lmtc_pkg::lcd_item_type   item,
   output lmtc_pkg::lcd_state_type  nxt_state,
   output lmtc_pkg::lcd_result_type result
);
   import lmtc_pkg::*;

   logic [10:0] dots;
   logic [7:0]  line_inc;
   logic        lcd_on;
   logic        coinc;

   always_comb begin
      nxt_state = cur_state;
      result    = '0;
      lcd_on    = cur_state.control[CTRL_LCD_ON];
      dots      = {1'b0, cur_state.dot} + {3'b000, item.cycles};
      line_inc  = cur_state.line + 8'd1;
      coinc     = 1'b0;

      unique case (item.action)
         // While the LCD is on, a tick adds its dots and makes at most one mode transition.
         ACT_TICK: begin
            if (lcd_on) begin
               unique case (cur_state.status[1:0])
                  MODE_OAM: begin
                     if (dots >= DOTS_OAM) begin
                        dots = dots - DOTS_OAM;
                        nxt_state.status[1:0] = MODE_XFER;
                        result.line_start = (cur_state.line < FIRST_VBLANK);
                     end
                  end
                  MODE_XFER: begin
                     if (dots >= DOTS_XFER) begin
                        dots = dots - DOTS_XFER;
                        nxt_state.status[1:0] = MODE_HBLANK;
                        if (cur_state.status[ST_EN_HBLANK]) result.status_irq = 1'b1;
                     end
                  end
                  MODE_HBLANK: begin
                     if (dots >= DOTS_HBLANK) begin
                        dots = dots - DOTS_HBLANK;
                        nxt_state.line = line_inc;
                        coinc = (line_inc == cur_state.compare);
                        nxt_state.status[ST_COINC] = coinc;
                        if (coinc && cur_state.status[ST_EN_COINC]) result.status_irq = 1'b1;
                        if (line_inc == FIRST_VBLANK) begin
                           result.frame_done = 1'b1;
                           result.vblank_irq = 1'b1;
                           nxt_state.status[1:0] = MODE_VBLANK;
                           if (cur_state.status[ST_EN_VBLANK]) result.status_irq = 1'b1;
                        end else begin
                           nxt_state.status[1:0] = MODE_OAM;
                           if (cur_state.status[ST_EN_OAM]) result.status_irq = 1'b1;
                        end
                     end
                  end
                  MODE_VBLANK: begin
                     if (dots >= DOTS_LINE) begin
                        dots = dots - DOTS_LINE;
                        if (line_inc > LAST_LINE) begin
                           nxt_state.line = '0;
                           nxt_state.status[1:0] = MODE_OAM;
                           if (cur_state.status[ST_EN_OAM]) result.status_irq = 1'b1;
                           coinc = (cur_state.compare == 8'd0);
                        end else begin
                           nxt_state.line = line_inc;
                           coinc = (line_inc == cur_state.compare);
                        end
                        nxt_state.status[ST_COINC] = coinc;
                        if (coinc && cur_state.status[ST_EN_COINC]) result.status_irq = 1'b1;
                     end
                  end
                  default: ;
               endcase
               // The dot counter saturates rather than wrapping.
               nxt_state.dot = (dots > DOT_MAX) ? DOT_MAX[9:0] : dots[9:0];
            end
         end

         // Register writes; the current line register ignores writes.
         ACT_WRITE: begin
            unique case (item.reg_sel)
               REG_CONTROL: begin
                  nxt_state.control = item.write_data;
                  if (lcd_on && !item.write_data[CTRL_LCD_ON]) begin
                     nxt_state.line = '0;
                     nxt_state.dot  = '0;
                     nxt_state.status[1:0] = MODE_HBLANK;
                  end
               end
               REG_STATUS: begin
                  nxt_state.status = (cur_state.status & STATUS_KEEP)
                                   | (item.write_data & STATUS_WRITE);
               end
               REG_COMPARE: begin
                  nxt_state.compare = item.write_data;
                  if (lcd_on) begin
                     coinc = (cur_state.line == item.write_data);
                     nxt_state.status[ST_COINC] = coinc;
                     if (coinc && cur_state.status[ST_EN_COINC]) result.status_irq = 1'b1;
                  end
               end
               REG_LINE: ;
               default: ;
            endcase
         end

         // Register reads; status always reads with its top bit set.
         ACT_READ: begin
            unique case (item.reg_sel)
               REG_CONTROL: result.read_data = cur_state.control;
               REG_STATUS:  result.read_data = cur_state.status | STATUS_READ;
               REG_LINE:    result.read_data = cur_state.line;
               REG_COMPARE: result.read_data = cur_state.compare;
               default:     result.read_data = '0;
            endcase
         end

         ACT_NONE: ;
         default: ;
      endcase

      result.line_num = nxt_state.line;
      result.cur_mode = nxt_state.status[1:0];
   end

endmodule
`default_nettype wire
